[sv/rv32x_pkg.sv]
// Shared types, constants and helpers of the RV32I subset execute unit.
package rv32x_pkg;

  localparam int unsigned XLen     = 32;
  localparam int unsigned RegCount = 32;
  localparam int unsigned RegIdxW  = $clog2(RegCount);
  localparam int unsigned PAddrW   = 3;

  localparam logic [XLen-1:0] PcStep    = 32'd4;
  localparam logic [XLen-1:0] JalrMask  = 32'hFFFF_FFFE;
  localparam logic [XLen-1:0] SignBit   = 32'h8000_0000;

  // Register index taken from paddr[2]; only start_pc exists.
  localparam logic [0:0] CfgStartPc = 1'b0;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_ADDI = 5'd2,
    OP_SLLI = 5'd3,
    OP_BEQ  = 5'd4,
    OP_BNE  = 5'd5,
    OP_JAL  = 5'd6,
    OP_JALR = 5'd7,
    OP_LUI  = 5'd8,
    OP_ORI  = 5'd9,
    OP_ANDI = 5'd10,
    OP_XORI = 5'd11,
    OP_SLL  = 5'd12,
    OP_SRL  = 5'd13,
    OP_SRA  = 5'd14,
    OP_OR   = 5'd15,
    OP_AND  = 5'd16,
    OP_XOR  = 5'd17,
    OP_SLT  = 5'd18,
    OP_SLTU = 5'd19
  } op_e;

  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_FWD  = 2'd1,
    SRC_MEM  = 2'd2
  } opnd_src_e;

  typedef struct packed {
    logic [4:0]         opcode;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic signed [31:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        wb_enable;
    logic [4:0]  wb_index;
    logic [31:0] wb_value;
    logic        branch_taken;
  } out_item_t;

  typedef struct packed {
    logic            en;
    logic [4:0]      addr;
    logic [XLen-1:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic [XLen-1:0] next_pc;
    logic            writes;
    logic [XLen-1:0] value;
    logic            taken;
  } alu_res_t;

  // Indices at or above the register count read as zero and drop writes.
  function automatic logic reg_in_range(input logic [4:0] idx);
    return {1'b0, idx} < 6'(RegCount);
  endfunction

endpackage

[sv/rv32i_subset_execute_unit.sv]
// Execute unit for a subset of RV32I: operand read, ALU, PC update and result register.
// An accepted word and its operand reads are registered; the ALU result then goes to the
// result register, and next_pc to pc_q, when the result register is free or being read.
// Throughput: one word per cycle while the result register is free or being read;
// out_ready_i reaches in_ready_o combinationally, so the output is not decoupled.
// Reset clears the PC and start_pc to zero; register file entries read as zero until
// first written, tracked by per-entry valid bits cleared by reset.
module rv32i_subset_execute_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rv32x_pkg::in_item_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rv32x_pkg::out_item_t          out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rv32x_pkg::PAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic                       in_accept, ex_advance, cfg_wr, sel_start_pc;
  logic                       ex_valid_q, out_valid_q, wr_ok;
  rv32x_pkg::in_item_t        ex_item_q;
  rv32x_pkg::out_item_t       out_d, out_q;
  logic [31:0]                pc_d, pc_q, start_pc_q;
  logic [rv32x_pkg::XLen-1:0] opa, opb;
  rv32x_pkg::rf_wr_t          rf_wr;
  rv32x_pkg::alu_res_t        alu_res;

  assign ex_advance = ex_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !ex_valid_q || ex_advance;
  assign in_accept  = in_valid_i && in_ready_o;

  rv32x_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_accept),
    .rd_addr_a_i (in_data_i.src_reg_a),
    .rd_addr_b_i (in_data_i.src_reg_b),
    .wr_i        (rf_wr),
    .rd_data_a_o (opa),
    .rd_data_b_o (opb)
  );

  rv32x_alu u_alu (
    .opcode_i (ex_item_q.opcode),
    .opa_i    (opa),
    .opb_i    (opb),
    .imm_i    (ex_item_q.immediate),
    .pc_i     (pc_q),
    .res_o    (alu_res)
  );

  // x0 and out-of-range destinations never take a write.
  assign wr_ok = alu_res.writes && ex_item_q.dest_reg != 5'd0 &&
                 rv32x_pkg::reg_in_range(ex_item_q.dest_reg);

  always_comb begin
    rf_wr.en   = ex_advance && wr_ok;
    rf_wr.addr = ex_item_q.dest_reg;
    rf_wr.data = alu_res.value;
  end

  always_comb begin
    out_d.next_pc      = alu_res.next_pc;
    out_d.wb_enable    = wr_ok;
    out_d.wb_index     = wr_ok ? ex_item_q.dest_reg : 5'd0;
    out_d.wb_value     = wr_ok ? alu_res.value : '0;
    out_d.branch_taken = alu_res.taken;
  end

  assign sel_start_pc = paddr[rv32x_pkg::PAddrW-1:2] == rv32x_pkg::CfgStartPc;
  assign cfg_wr       = psel && penable && pwrite && sel_start_pc;
  assign pready       = 1'b1;
  assign prdata       = sel_start_pc ? start_pc_q : 32'd0;

  always_comb begin
    pc_d = pc_q;
    if (cfg_wr) begin
      pc_d = pwdata;
    end else if (ex_advance) begin
      pc_d = alu_res.next_pc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
      start_pc_q  <= '0;
    end else begin
      if (in_ready_o) begin
        ex_valid_q <= in_valid_i;
      end
      if (ex_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      pc_q <= pc_d;
      if (cfg_wr) begin
        start_pc_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ex_item_q <= in_data_i;
    end
    if (ex_advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled although the result register is empty");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_advance |=> out_valid_q)
    else $error("advancing word did not reach the result register");

  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.en |-> rf_wr.addr != 5'd0)
    else $error("register x0 written");

  a_quiet_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.wb_enable |-> out_q.wb_index == 5'd0 && out_q.wb_value == 32'd0)
    else $error("write-back fields not cleared without a write");
`endif

endmodule

[sv/rv32x_regfile.sv]
// Register file with registered reads, write bypass and per-entry valid bits.
module rv32x_regfile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [4:0]                    rd_addr_a_i,
  input  logic [4:0]                    rd_addr_b_i,
  input  rv32x_pkg::rf_wr_t             wr_i,
  output logic [rv32x_pkg::XLen-1:0]    rd_data_a_o,
  output logic [rv32x_pkg::XLen-1:0]    rd_data_b_o
);

  logic [rv32x_pkg::XLen-1:0]     mem_q [rv32x_pkg::RegCount];
  logic [rv32x_pkg::RegCount-1:0] valid_q;
  logic [rv32x_pkg::XLen-1:0]     rdata_a_q, rdata_b_q, fwd_q;
  rv32x_pkg::opnd_src_e           sel_a_d, sel_a_q, sel_b_d, sel_b_q;

  function automatic rv32x_pkg::opnd_src_e pick_src(
    input logic [4:0]              addr,
    input rv32x_pkg::rf_wr_t       wr,
    input logic [rv32x_pkg::RegCount-1:0] valid
  );
    rv32x_pkg::opnd_src_e src;
    if (addr == 5'd0 || !rv32x_pkg::reg_in_range(addr)) begin
      src = rv32x_pkg::SRC_ZERO;
    end else if (wr.en && wr.addr == addr) begin
      src = rv32x_pkg::SRC_FWD;
    end else if (!valid[addr[rv32x_pkg::RegIdxW-1:0]]) begin
      src = rv32x_pkg::SRC_ZERO;
    end else begin
      src = rv32x_pkg::SRC_MEM;
    end
    return src;
  endfunction

  always_comb begin
    sel_a_d = pick_src(rd_addr_a_i, wr_i, valid_q);
    sel_b_d = pick_src(rd_addr_b_i, wr_i, valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[rv32x_pkg::RegIdxW-1:0]] <= wr_i.data;
    end
  end

  // Reads see the old contents; a write in the same cycle goes through fwd_q.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_a_q <= mem_q[rd_addr_a_i[rv32x_pkg::RegIdxW-1:0]];
      rdata_b_q <= mem_q[rd_addr_b_i[rv32x_pkg::RegIdxW-1:0]];
      fwd_q     <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      sel_a_q <= rv32x_pkg::SRC_ZERO;
      sel_b_q <= rv32x_pkg::SRC_ZERO;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr[rv32x_pkg::RegIdxW-1:0]] <= 1'b1;
      end
      if (rd_en_i) begin
        sel_a_q <= sel_a_d;
        sel_b_q <= sel_b_d;
      end
    end
  end

  always_comb begin
    case (sel_a_q)
      rv32x_pkg::SRC_FWD: rd_data_a_o = fwd_q;
      rv32x_pkg::SRC_MEM: rd_data_a_o = rdata_a_q;
      default:            rd_data_a_o = '0;
    endcase
    case (sel_b_q)
      rv32x_pkg::SRC_FWD: rd_data_b_o = fwd_q;
      rv32x_pkg::SRC_MEM: rd_data_b_o = rdata_b_q;
      default:            rd_data_b_o = '0;
    endcase
  end

endmodule

[sv/rv32x_alu.sv]
// Operation decoder, ALU and next-PC logic for one instruction.
module rv32x_alu (
  input  logic [4:0]                 opcode_i,
  input  logic [rv32x_pkg::XLen-1:0] opa_i,
  input  logic [rv32x_pkg::XLen-1:0] opb_i,
  input  logic [rv32x_pkg::XLen-1:0] imm_i,
  input  logic [rv32x_pkg::XLen-1:0] pc_i,
  output rv32x_pkg::alu_res_t        res_o
);

  logic [rv32x_pkg::XLen-1:0] seq_pc, br_pc;
  logic [4:0]                 sh_b;

  assign seq_pc = pc_i + rv32x_pkg::PcStep;
  assign br_pc  = pc_i + imm_i;
  assign sh_b   = opb_i[4:0];

  always_comb begin
    res_o.next_pc = seq_pc;
    res_o.writes  = 1'b1;
    res_o.value   = '0;
    res_o.taken   = 1'b0;
    unique case (rv32x_pkg::op_e'(opcode_i))
      rv32x_pkg::OP_ADD:  res_o.value = opa_i + opb_i;
      rv32x_pkg::OP_SUB:  res_o.value = opa_i - opb_i;
      rv32x_pkg::OP_ADDI: res_o.value = opa_i + imm_i;
      rv32x_pkg::OP_SLLI: res_o.value = opa_i << imm_i[4:0];
      rv32x_pkg::OP_BEQ: begin
        res_o.writes = 1'b0;
        if (opa_i == opb_i) begin
          res_o.next_pc = br_pc;
          res_o.taken   = 1'b1;
        end
      end
      rv32x_pkg::OP_BNE: begin
        res_o.writes = 1'b0;
        if (opa_i != opb_i) begin
          res_o.next_pc = br_pc;
          res_o.taken   = 1'b1;
        end
      end
      rv32x_pkg::OP_JAL: begin
        res_o.value   = seq_pc;
        res_o.next_pc = br_pc;
        res_o.taken   = 1'b1;
      end
      rv32x_pkg::OP_JALR: begin
        res_o.value   = seq_pc;
        res_o.next_pc = (opa_i + imm_i) & rv32x_pkg::JalrMask;
        res_o.taken   = 1'b1;
      end
      rv32x_pkg::OP_LUI:  res_o.value = imm_i;
      rv32x_pkg::OP_ORI:  res_o.value = opa_i | imm_i;
      rv32x_pkg::OP_ANDI: res_o.value = opa_i & imm_i;
      rv32x_pkg::OP_XORI: res_o.value = opa_i ^ imm_i;
      rv32x_pkg::OP_SLL:  res_o.value = opa_i << sh_b;
      rv32x_pkg::OP_SRL:  res_o.value = opa_i >> sh_b;
      rv32x_pkg::OP_SRA:  res_o.value = $unsigned($signed(opa_i) >>> sh_b);
      rv32x_pkg::OP_OR:   res_o.value = opa_i | opb_i;
      rv32x_pkg::OP_AND:  res_o.value = opa_i & opb_i;
      rv32x_pkg::OP_XOR:  res_o.value = opa_i ^ opb_i;
      rv32x_pkg::OP_SLT: begin
        res_o.value = {31'd0, (opa_i ^ rv32x_pkg::SignBit) < (opb_i ^ rv32x_pkg::SignBit)};
      end
      rv32x_pkg::OP_SLTU: res_o.value = {31'd0, opa_i < opb_i};
      default:            res_o.writes = 1'b0;
    endcase
  end

endmodule
